@@ src/ept_pkg.sv @@
// shared types, constants and helpers for the encoder position/velocity tracker
// no dependencies; imported by every module of the block
package ept_pkg;

   // angle resolution and offset table size
   localparam int ANGLE_BITS  = 21;
   localparam int LUT_ENTRIES = 128;

   // operation codes of an input beat
   localparam logic OP_SAMPLE    = 1'b0;
   localparam logic OP_LUT_WRITE = 1'b1;

   // configuration register indexes
   localparam logic [2:0] CSR_MECH_ZERO  = 3'd0;
   localparam logic [2:0] CSR_ELEC_OFFS  = 3'd1;
   localparam logic [2:0] CSR_POLE_PAIRS = 3'd2;
   localparam logic [2:0] CSR_SAMPLE_RT  = 3'd3;
   localparam logic [2:0] CSR_LPF_ALPHA  = 3'd4;
   localparam logic [2:0] CSR_LPF_BETA   = 3'd5;
   localparam logic [2:0] CSR_GEAR_INV   = 3'd6;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 22;

   // shared multiplier operand widths
   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 24;

   // moving-average sum width (48-bit values, up to 32 of them, plus sign)
   localparam int SUM_W = 54;

   // acceleration scale, fixed 40 kHz update
   localparam int ACCEL_RATE = 40000;

   localparam logic signed [47:0] SAT_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] SAT_MIN = 48'sh8000_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_TURN,
      ST_POS,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } ctrl_state_type;

   // which product the shared multiplier is working on
   typedef enum logic [3:0] {
      MS_INTERP,
      MS_EANG,
      MS_VEL,
      MS_ALPHA,
      MS_BETA,
      MS_EVEL,
      MS_FPOS,
      MS_FVEL,
      MS_FACC
   } mul_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic        accept;
      logic        rd_en;
      logic        rd_next;
      logic        cap_off1;
      logic        mul_start;
      logic        mul_cap;
      mul_sel_type mul_sel;
      logic        cap_turn;
      logic        cap_pos;
      logic        div_start;
      logic        div_cap;
      logic        out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic out_free;
   } status_type;

   // saturate to 48-bit two's complement
   function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
      logic signed [47:0] r;
      if (x > 66'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (x < 66'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = x[47:0];
      end
      return r;
   endfunction

endpackage

@@ src/ept_mul.sv @@
// shared 64x24 multiplier, two partial products: the low one registered, the high one added into the product register
// depends on ept_pkg
module ept_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [ept_pkg::MUL_A_W-1:0]   a,
   input  logic        [ept_pkg::MUL_B_W-1:0]   b,
   output logic                                 done,
   output logic signed [ept_pkg::MUL_A_W-1:0]   product
);
   import ept_pkg::*;

   logic signed [MUL_A_W-1:0]     a_ff;
   logic        [MUL_B_W-1:0]     b_ff;
   logic        [MUL_B_W+31:0]    plo_ff;
   logic        [MUL_B_W+31:0]    plo_in;
   logic signed [MUL_B_W+32:0]    phi;
   logic signed [MUL_A_W-1:0]     product_ff;
   logic signed [MUL_A_W-1:0]     product_in;
   logic [1:0]                    stage_ff;
   logic                          done_ff;

   // low half unsigned, high half signed
   assign plo_in = (MUL_B_W+32)'(a_ff[31:0]) * (MUL_B_W+32)'(b_ff);
   assign phi = $signed(a_ff[63:32]) * $signed({1'b0, b_ff});
   assign product_in = $signed({phi[31:0], 32'd0}) + $signed(MUL_A_W'(plo_ff));

   // stage sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (stage_ff == 2'd2);
         if (start) begin
            stage_ff <= 2'd1;
         end else if (stage_ff == 2'd1) begin
            stage_ff <= 2'd2;
         end else begin
            stage_ff <= 2'd0;
         end
      end
   end

   // operand and partial product registers
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
      if (stage_ff == 2'd1) begin
         plo_ff <= plo_in;
      end
      if (stage_ff == 2'd2) begin
         product_ff <= product_in;
      end
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

@@ src/ept_div.sv @@
// divider by a constant depth for the moving average, nine quotient bits per cycle
// depends on ept_pkg; each digit by reciprocal multiply, truncates toward zero
module ept_div #(
   parameter int DEPTH = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [ept_pkg::SUM_W-1:0]   dividend,
   output logic                               done,
   output logic signed [47:0]                 quotient
);
   import ept_pkg::*;

   localparam int CH    = 9;
   localparam int STEPS = (SUM_W + CH - 1) / CH;
   localparam int PW    = STEPS * CH;
   localparam int RW    = $clog2(DEPTH) + 1;
   localparam int XW    = RW + CH;
   localparam int SH    = XW + $clog2(DEPTH);
   localparam int MW    = SH + 1;
   localparam int CW    = $clog2(STEPS + 1);
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

   logic [PW-1:0]    work_ff;
   logic [RW-1:0]    rem_ff;
   logic [XW-1:0]    part;
   logic [XW+MW-1:0] prod;
   logic [CH-1:0]    digit;
   logic [XW-1:0]    rem_in;
   logic             neg_ff;
   logic [CW-1:0]    cnt_ff;
   logic             done_ff;
   logic [SUM_W-1:0] mag;
   logic [SUM_W-1:0] qsigned;

   // one quotient digit: remainder and next chunk over the constant depth
   assign part    = {rem_ff, work_ff[PW-1 -: CH]};
   assign prod    = (XW+MW)'(part) * (XW+MW)'(RECIP);
   assign digit   = prod[SH +: CH];
   assign rem_in  = part - XW'(digit) * XW'(DEPTH);
   assign mag     = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
   assign qsigned = neg_ff ? (SUM_W'(0) - SUM_W'(work_ff)) : SUM_W'(work_ff);

   // iteration counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == CW'(1));
         if (start) begin
            cnt_ff <= CW'(STEPS);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   // digit recurrence, quotient digits shift in from the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= dividend[SUM_W-1];
         work_ff <= PW'(mag);
         rem_ff  <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff  <= rem_in[RW-1:0];
         work_ff <= {work_ff[PW-CH-1:0], digit};
      end
   end

   assign done     = done_ff;
   assign quotient = qsigned[47:0];

endmodule

@@ src/ept_ctrl.sv @@
// sequencer for the tracker: input handshake, multiplier and divider steps
// depends on ept_pkg
module ept_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_operation,
   output logic                   req_stall,
   output ept_pkg::cmd_type       cmd,
   input  ept_pkg::status_type    status
);
   import ept_pkg::*;

   ctrl_state_type state_ff, state_in;
   mul_sel_type    msel_ff, msel_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         msel_ff  <= MS_INTERP;
      end else begin
         state_ff <= state_in;
         msel_ff  <= msel_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      msel_in     = msel_ff;
      cmd         = '0;
      cmd.mul_sel = msel_ff;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_operation == OP_SAMPLE) begin
                  state_in = ST_RD_A;
               end
            end
         end
         ST_RD_A: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_next  = 1'b1;
            cmd.cap_off1 = 1'b1;
            msel_in      = MS_INTERP;
            state_in     = ST_MUL_GO;
         end
         ST_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            cmd.mul_cap = 1'b1;
            if (status.mul_done) begin
               case (msel_ff)
                  MS_INTERP: state_in = ST_TURN;
                  MS_EANG: begin
                     msel_in  = MS_VEL;
                     state_in = ST_MUL_GO;
                  end
                  MS_VEL: begin
                     msel_in  = MS_ALPHA;
                     state_in = ST_MUL_GO;
                  end
                  MS_ALPHA: begin
                     msel_in  = MS_BETA;
                     state_in = ST_MUL_GO;
                  end
                  MS_BETA: state_in = ST_DIV_GO;
                  MS_EVEL: begin
                     msel_in  = MS_FPOS;
                     state_in = ST_MUL_GO;
                  end
                  MS_FPOS: begin
                     msel_in  = MS_FVEL;
                     state_in = ST_MUL_GO;
                  end
                  MS_FVEL: begin
                     msel_in  = MS_FACC;
                     state_in = ST_MUL_GO;
                  end
                  MS_FACC: state_in = ST_OUT;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_TURN: begin
            cmd.cap_turn = 1'b1;
            state_in     = ST_POS;
         end
         ST_POS: begin
            cmd.cap_pos = 1'b1;
            msel_in     = MS_EANG;
            state_in    = ST_MUL_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            cmd.div_cap = 1'b1;
            if (status.div_done) begin
               msel_in  = MS_EVEL;
               state_in = ST_MUL_GO;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ src/ept_datapath.sv @@
// tracker datapath: offset table, config registers, tracking state, output beat
// depends on ept_pkg, ept_mul, ept_div
module ept_datapath #(
   parameter int AVERAGE_DEPTH = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ept_pkg::cmd_type                    cmd,
   output ept_pkg::status_type                 status,
   input  logic                                req_operation,
   input  logic [20:0]                         req_raw_angle,
   input  logic [6:0]                          req_lut_index,
   input  logic signed [17:0]                  req_lut_value,
   input  logic                                csr_valid,
   input  logic [ept_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ept_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [47:0]                  rsp_multiturn_position,
   output logic signed [47:0]                  rsp_rotor_velocity,
   output logic [20:0]                         rsp_electrical_angle,
   output logic signed [47:0]                  rsp_electrical_velocity,
   output logic signed [47:0]                  rsp_flange_position,
   output logic signed [47:0]                  rsp_flange_velocity,
   output logic signed [47:0]                  rsp_flange_acceleration
);
   import ept_pkg::*;

   localparam int AB   = ANGLE_BITS;
   localparam int LA   = $clog2(LUT_ENTRIES);
   localparam int SCW  = AB + LA + 1;
   localparam int CW   = ((AB > 19) ? AB : 19) + 2;
   localparam int EW   = ((CW > 23) ? CW : 23) + 2;
   localparam int HD   = (AVERAGE_DEPTH > 1) ? AVERAGE_DEPTH - 1 : 1;
   localparam logic signed [EW-1:0] HALF_E = EW'(2 ** (AB - 1));

   // configuration registers
   logic [20:0]        mech_zero_ff;
   logic signed [21:0] elec_offs_ff;
   logic [6:0]         pole_ff;
   logic [15:0]        rate_ff;
   logic [15:0]        alpha_ff;
   logic [15:0]        beta_ff;
   logic [15:0]        gear_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mech_zero_ff <= '0;
         elec_offs_ff <= '0;
         pole_ff      <= 7'd1;
         rate_ff      <= 16'd40000;
         alpha_ff     <= 16'hFFFF;
         beta_ff      <= '0;
         gear_ff      <= 16'hFFFF;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MECH_ZERO:  mech_zero_ff <= csr_data[20:0];
            CSR_ELEC_OFFS:  elec_offs_ff <= $signed(csr_data[21:0]);
            CSR_POLE_PAIRS: pole_ff      <= csr_data[6:0];
            CSR_SAMPLE_RT:  rate_ff      <= csr_data[15:0];
            CSR_LPF_ALPHA:  alpha_ff     <= csr_data[15:0];
            CSR_LPF_BETA:   beta_ff      <= csr_data[15:0];
            CSR_GEAR_INV:   gear_ff      <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // offset table memory
   logic signed [17:0] lut_mem [LUT_ENTRIES];
   logic signed [17:0] rdata_ff;
   logic [LA-1:0]      rd_addr;
   logic               lut_wr;

   assign lut_wr = cmd.accept && (req_operation == OP_LUT_WRITE)
                   && (int'(req_lut_index) < LUT_ENTRIES);

   always_ff @(posedge clock) begin
      if (lut_wr) begin
         lut_mem[LA'(req_lut_index)] <= req_lut_value;
      end
      if (cmd.rd_en) begin
         rdata_ff <= lut_mem[rd_addr];
      end
   end

   // sector and fraction of the latched angle
   logic [AB-1:0]  raw_ff;
   logic [SCW-1:0] scaled;
   logic [LA:0]    sec_wide;
   logic [LA-1:0]  sector;
   logic [LA-1:0]  nxt;
   logic [AB-1:0]  frac;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         raw_ff <= AB'(req_raw_angle);
      end
   end

   assign scaled   = SCW'(raw_ff) * SCW'(LUT_ENTRIES);
   assign sec_wide = scaled[SCW-1:AB];
   assign sector   = (sec_wide >= (LA+1)'(LUT_ENTRIES)) ? LA'(LUT_ENTRIES - 1)
                                                         : sec_wide[LA-1:0];
   assign nxt      = (sector == LA'(LUT_ENTRIES - 1)) ? '0 : sector + LA'(1);
   assign frac     = scaled[AB-1:0];
   assign rd_addr  = cmd.rd_next ? nxt : sector;

   // shared multiplier
   logic                      mul_done;
   logic signed [MUL_A_W-1:0] mul_res;
   logic signed [MUL_A_W-1:0] mul_a;
   logic        [MUL_B_W-1:0] mul_b;
   logic signed [18:0]        off_diff;

   logic signed [17:0]  off1_ff;
   logic signed [CW-1:0] corr_ff;
   logic signed [CW-1:0] prev_corr_ff;
   logic signed [15:0]  turn_ff;
   logic                first_ff;
   logic signed [47:0]  pos_ff;
   logic signed [47:0]  prev_pos_ff;
   logic signed [48:0]  delta_ff;
   logic signed [47:0]  vraw_ff;
   logic signed [63:0]  pa_ff;
   logic signed [47:0]  filt_ff;
   logic signed [47:0]  avg_ff;
   logic [AB-1:0]       eang_ff;
   logic signed [47:0]  evel_ff;
   logic signed [47:0]  fpos_ff;
   logic signed [47:0]  fvel_ff;
   logic signed [47:0]  prevf_ff;
   logic signed [47:0]  facc_ff;
   logic                div_done;
   logic signed [47:0]  div_q;

   assign off_diff = 19'(rdata_ff) - 19'(off1_ff);

   // operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MS_INTERP: begin
            mul_a = MUL_A_W'(off_diff);
            mul_b = MUL_B_W'(frac);
         end
         MS_EANG: begin
            mul_a = MUL_A_W'(corr_ff);
            mul_b = MUL_B_W'(pole_ff);
         end
         MS_VEL: begin
            mul_a = MUL_A_W'(delta_ff);
            mul_b = MUL_B_W'(rate_ff);
         end
         MS_ALPHA: begin
            mul_a = MUL_A_W'(vraw_ff);
            mul_b = MUL_B_W'(alpha_ff);
         end
         MS_BETA: begin
            mul_a = MUL_A_W'(avg_ff);
            mul_b = MUL_B_W'(beta_ff);
         end
         MS_EVEL: begin
            mul_a = MUL_A_W'(avg_ff);
            mul_b = MUL_B_W'(pole_ff);
         end
         MS_FPOS: begin
            mul_a = MUL_A_W'(pos_ff);
            mul_b = MUL_B_W'(gear_ff);
         end
         MS_FVEL: begin
            mul_a = MUL_A_W'(avg_ff);
            mul_b = MUL_B_W'(gear_ff);
         end
         MS_FACC: begin
            mul_a = MUL_A_W'(sat48(66'(fvel_ff) - 66'(prevf_ff)));
            mul_b = MUL_B_W'(ACCEL_RATE);
         end
         default: ;
      endcase
   end

   ept_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_res)
   );

   // turn count step
   logic signed [EW-1:0] d_e;
   logic signed [EW-1:0] corr_e;
   logic signed [EW-1:0] zero_e;
   logic signed [15:0]   turn_in;

   assign corr_e = EW'(corr_ff);
   assign d_e    = corr_e - EW'(prev_corr_ff);
   assign zero_e = EW'($signed({1'b0, mech_zero_ff}));

   always_comb begin
      turn_in = turn_ff;
      if (!first_ff) begin
         if (d_e > HALF_E) begin
            turn_in = turn_ff - 16'sd1;
         end else if (d_e < -HALF_E) begin
            turn_in = turn_ff + 16'sd1;
         end
      end else if (zero_e > HALF_E) begin
         if (corr_e < zero_e - HALF_E) begin
            turn_in = turn_ff + 16'sd1;
         end
      end else if (corr_e > zero_e + HALF_E) begin
         turn_in = turn_ff - 16'sd1;
      end
   end

   // position from corrected angle and turns
   logic signed [47:0] pos_in;
   assign pos_in = 48'(corr_ff) + (48'(turn_ff) <<< AB)
                   - 48'($signed({1'b0, mech_zero_ff}));

   // tracking state and product captures
   logic cap;
   assign cap = cmd.mul_cap && mul_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_corr_ff <= CW'(HALF_E);
         turn_ff      <= '0;
         first_ff     <= 1'b1;
         prev_pos_ff  <= '0;
         avg_ff       <= '0;
         prevf_ff     <= '0;
      end else begin
         if (cmd.cap_turn) begin
            turn_ff      <= turn_in;
            first_ff     <= 1'b0;
            prev_corr_ff <= corr_ff;
         end
         if (cmd.cap_pos) begin
            prev_pos_ff <= pos_in;
         end
         if (cmd.div_cap && div_done) begin
            avg_ff <= div_q;
         end
         if (cap && (cmd.mul_sel == MS_FACC)) begin
            prevf_ff <= fvel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_off1) begin
         off1_ff <= rdata_ff;
      end
      if (cmd.cap_pos) begin
         pos_ff   <= pos_in;
         delta_ff <= 49'(pos_in) - 49'(prev_pos_ff);
      end
      if (cap) begin
         case (cmd.mul_sel)
            MS_INTERP: corr_ff <= CW'($signed({1'b0, raw_ff})) + CW'(off1_ff)
                                  + CW'(mul_res >>> AB);
            MS_EANG:   eang_ff <= mul_res[AB-1:0] + AB'(elec_offs_ff);
            MS_VEL:    vraw_ff <= sat48(66'(mul_res));
            MS_ALPHA:  pa_ff   <= mul_res;
            MS_BETA:   filt_ff <= sat48((66'(pa_ff) + 66'(mul_res)) >>> 16);
            MS_EVEL:   evel_ff <= sat48(66'(mul_res));
            MS_FPOS:   fpos_ff <= sat48(66'(mul_res >>> 16));
            MS_FVEL:   fvel_ff <= sat48(66'(mul_res >>> 16));
            MS_FACC:   facc_ff <= sat48(66'(mul_res));
            default: ;
         endcase
      end
   end

   // moving-average history and running sum of the newest depth-1 values
   logic signed [SUM_W-1:0] run_ff;
   logic signed [47:0]      hist_ff [HD];

   generate
      if (AVERAGE_DEPTH > 1) begin : g_hist
         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff <= '0;
               for (int i = 0; i < HD; i++) begin
                  hist_ff[i] <= '0;
               end
            end else if (cmd.div_cap && div_done) begin
               run_ff     <= run_ff + SUM_W'(filt_ff) - SUM_W'(hist_ff[HD-1]);
               hist_ff[0] <= filt_ff;
               for (int i = 1; i < HD; i++) begin
                  hist_ff[i] <= hist_ff[i-1];
               end
            end
         end
      end else begin : g_nohist
         always_ff @(posedge clock) begin
            run_ff     <= '0;
            hist_ff[0] <= '0;
         end
      end
   endgenerate

   ept_div #(
      .DEPTH (AVERAGE_DEPTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (SUM_W'(filt_ff) + run_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // output beat register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_multiturn_position  <= pos_ff;
         rsp_rotor_velocity      <= avg_ff;
         rsp_electrical_angle    <= 21'(eang_ff);
         rsp_electrical_velocity <= evel_ff;
         rsp_flange_position     <= fpos_ff;
         rsp_flange_velocity     <= fvel_ff;
         rsp_flange_acceleration <= facc_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

@@ src/encoder_position_velocity_tracker.sv @@
// encoder multi-turn position / velocity tracker, top level
// a table write beat is written to the table when taken and gives no result
// a sample beat is worked through in order: two table reads, the first of nine products on the
// shared multiplier, turn and position steps, four products, the divider, four more products
// one sample at a time; a finished beat waits in the output register
// synchronous active-high reset clears state and config; offset table is not cleared
module encoder_position_velocity_tracker #(
   parameter int AVERAGE_DEPTH = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [20:0]                         req_raw_angle,
   input  logic [6:0]                          req_lut_index,
   input  logic signed [17:0]                  req_lut_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [47:0]                  rsp_multiturn_position,
   output logic signed [47:0]                  rsp_rotor_velocity,
   output logic [20:0]                         rsp_electrical_angle,
   output logic signed [47:0]                  rsp_electrical_velocity,
   output logic signed [47:0]                  rsp_flange_position,
   output logic signed [47:0]                  rsp_flange_velocity,
   output logic signed [47:0]                  rsp_flange_acceleration,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ept_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ept_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ept_pkg::*;

   cmd_type    cmd;
   status_type status;

   // config writes always taken
   assign csr_ready = 1'b1;

   ept_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .status        (status)
   );

   ept_datapath #(
      .AVERAGE_DEPTH (AVERAGE_DEPTH)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_operation           (req_operation),
      .req_raw_angle           (req_raw_angle),
      .req_lut_index           (req_lut_index),
      .req_lut_value           (req_lut_value),
      .csr_valid               (csr_valid && csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_multiturn_position  (rsp_multiturn_position),
      .rsp_rotor_velocity      (rsp_rotor_velocity),
      .rsp_electrical_angle    (rsp_electrical_angle),
      .rsp_electrical_velocity (rsp_electrical_velocity),
      .rsp_flange_position     (rsp_flange_position),
      .rsp_flange_velocity     (rsp_flange_velocity),
      .rsp_flange_acceleration (rsp_flange_acceleration)
   );

endmodule

@@ tb/tb.sv @@
// self-checking testbench for encoder_position_velocity_tracker
// depends on ept_pkg and the tracker rtl; predicts every result beat in-line
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ept_pkg::*;

   typedef logic signed [95:0] wide_type;

   typedef struct {
      logic               op;
      logic [20:0]        angle;
      logic [6:0]         idx;
      logic signed [17:0] val;
   } enc_beat_type;

   typedef struct {
      logic signed [47:0] pos;
      logic signed [47:0] rvel;
      logic [20:0]        eang;
      logic signed [47:0] evel;
      logic signed [47:0] fpos;
      logic signed [47:0] fvel;
      logic signed [47:0] facc;
   } track_type;

   localparam wide_type RES  = 96'sd2097152;
   localparam wide_type HALF = 96'sd1048576;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_operation = OP_SAMPLE;
   logic [20:0] req_raw_angle = '0;
   logic [6:0] req_lut_index = '0;
   logic signed [17:0] req_lut_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [47:0] rsp_multiturn_position, rsp_rotor_velocity;
   logic [20:0] rsp_electrical_angle;
   logic signed [47:0] rsp_electrical_velocity, rsp_flange_position;
   logic signed [47:0] rsp_flange_velocity, rsp_flange_acceleration;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   encoder_position_velocity_tracker uut (.*);

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // tracker model state and settings
   wide_type           offs_tbl [128];
   wide_type           last_corr;
   logic signed [15:0] turns;
   logic               first_pending;
   wide_type           last_pos;
   wide_type           vel_hist [10];
   wide_type           avg_vel;
   wide_type           last_fvel;
   wide_type           zero_cfg, eoff_cfg, pp_cfg, rate_cfg, alpha_cfg, beta_cfg, gear_cfg;

   enc_beat_type pending_beats[$];
   track_type    expected_tracks[$];
   int        errors = 0;
   bit        quiet = 1'b0;
   bit        hold_req = 1'b0;
   int        hold_cnt = 0;
   int        gap_cnt = 0;
   logic [20:0] angle_now = '0;

   function automatic logic signed [47:0] clip48(wide_type x);
      if (x > wide_type'(SAT_MAX)) return SAT_MAX;
      if (x < wide_type'(SAT_MIN)) return SAT_MIN;
      return x[47:0];
   endfunction

   // work out the result of one accepted beat
   task automatic track_beat(enc_beat_type b);
      wide_type off1, off2, frac, corr, pos, vraw, filt, sum, fvel;
      track_type t;
      logic [6:0] sect;
      if (b.op == OP_LUT_WRITE) begin
         offs_tbl[b.idx] = b.val;
         return;
      end
      sect = b.angle[20:14];
      frac = {b.angle[13:0], 7'b0};
      off1 = offs_tbl[sect];
      off2 = offs_tbl[7'(sect + 7'd1)];
      corr = wide_type'({1'b0, b.angle}) + off1 + (((off2 - off1) * frac) >>> 21);
      // turn counting, first sample from the mechanical zero
      if (!first_pending) begin
         if (corr - last_corr > HALF) turns = turns - 16'sd1;
         else if (corr - last_corr < -HALF) turns = turns + 16'sd1;
      end else begin
         if (zero_cfg > HALF) begin
            if (corr < zero_cfg - HALF) turns = turns + 16'sd1;
         end else if (corr > zero_cfg + HALF) begin
            turns = turns - 16'sd1;
         end
         first_pending = 1'b0;
      end
      last_corr = corr;
      pos = corr + wide_type'(turns) * RES - zero_cfg;
      vraw = clip48((pos - last_pos) * rate_cfg);
      last_pos = pos;
      filt = clip48((alpha_cfg * vraw + beta_cfg * avg_vel) >>> 16);
      // moving average over the last ten filtered values
      sum = filt;
      for (int i = 9; i >= 1; i--) begin
         vel_hist[i] = vel_hist[i-1];
         sum += vel_hist[i];
      end
      vel_hist[0] = filt;
      avg_vel = sum / 10;
      t.pos  = clip48(pos);
      t.rvel = avg_vel[47:0];
      t.eang = 21'(pp_cfg * corr + eoff_cfg);
      t.evel = clip48(pp_cfg * avg_vel);
      t.fpos = clip48((pos * gear_cfg) >>> 16);
      fvel   = clip48((avg_vel * gear_cfg) >>> 16);
      t.fvel = fvel[47:0];
      t.facc = clip48(wide_type'(clip48(fvel - last_fvel)) * ACCEL_RATE);
      last_fvel = fvel;
      expected_tracks.push_back(t);
   endtask

   // sender: one beat per handshake, random gaps
   always @(posedge clock) begin
      enc_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            track_beat('{req_operation, req_raw_angle, req_lut_index, req_lut_value});
         end
         if (!req_valid || !req_stall) begin
            if (gap_cnt > 0) begin
               gap_cnt--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               b = pending_beats.pop_front();
               req_operation <= b.op;
               req_raw_angle <= b.angle;
               req_lut_index <= b.idx;
               req_lut_value <= b.val;
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 5) == 0) gap_cnt = $urandom_range(1, 15);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: compare each result beat, random stalls
   always @(posedge clock) begin
      track_type t;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tracks.size() == 0) begin
               $display("%0t: unexpected result beat, position %0d", $time,
                        rsp_multiturn_position);
               errors++;
            end else begin
               t = expected_tracks.pop_front();
               if (rsp_multiturn_position !== t.pos) begin
                  $display("%0t: multiturn_position exp %0d got %0d", $time, t.pos,
                           rsp_multiturn_position);
                  errors++;
               end
               if (rsp_rotor_velocity !== t.rvel) begin
                  $display("%0t: rotor_velocity exp %0d got %0d", $time, t.rvel,
                           rsp_rotor_velocity);
                  errors++;
               end
               if (rsp_electrical_angle !== t.eang) begin
                  $display("%0t: electrical_angle exp %0d got %0d", $time, t.eang,
                           rsp_electrical_angle);
                  errors++;
               end
               if (rsp_electrical_velocity !== t.evel) begin
                  $display("%0t: electrical_velocity exp %0d got %0d", $time, t.evel,
                           rsp_electrical_velocity);
                  errors++;
               end
               if (rsp_flange_position !== t.fpos) begin
                  $display("%0t: flange_position exp %0d got %0d", $time, t.fpos,
                           rsp_flange_position);
                  errors++;
               end
               if (rsp_flange_velocity !== t.fvel) begin
                  $display("%0t: flange_velocity exp %0d got %0d", $time, t.fvel,
                           rsp_flange_velocity);
                  errors++;
               end
               if (rsp_flange_acceleration !== t.facc) begin
                  $display("%0t: flange_acceleration exp %0d got %0d", $time, t.facc,
                           rsp_flange_acceleration);
                  errors++;
               end
            end
         end
         // long hold-off on request, otherwise short bursts
         if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = 400;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_cnt = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_sample(logic [20:0] a);
      pending_beats.push_back('{OP_SAMPLE, a, 7'($urandom), 18'($urandom)});
   endtask

   task automatic push_lut(logic [6:0] i, logic signed [17:0] v);
      pending_beats.push_back('{OP_LUT_WRITE, 21'($urandom), i, v});
   endtask

   // register write, mirrored into the model on the handshake
   task automatic csr_write(logic [2:0] idx, logic [21:0] d);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MECH_ZERO:  zero_cfg  = d[20:0];
         CSR_ELEC_OFFS:  eoff_cfg  = $signed(d);
         CSR_POLE_PAIRS: pp_cfg    = d[6:0];
         CSR_SAMPLE_RT:  rate_cfg  = d[15:0];
         CSR_LPF_ALPHA:  alpha_cfg = d[15:0];
         CSR_LPF_BETA:   beta_cfg  = d[15:0];
         CSR_GEAR_INV:   gear_cfg  = d[15:0];
         default: ;
      endcase
   endtask

   task automatic set_all(logic [20:0] z, logic [21:0] e, logic [6:0] p, logic [15:0] r,
                          logic [15:0] a, logic [15:0] bt, logic [15:0] g);
      csr_write(CSR_MECH_ZERO, 22'(z));
      csr_write(CSR_ELEC_OFFS, e);
      csr_write(CSR_POLE_PAIRS, 22'(p));
      csr_write(CSR_SAMPLE_RT, 22'(r));
      csr_write(CSR_LPF_ALPHA, 22'(a));
      csr_write(CSR_LPF_BETA, 22'(bt));
      csr_write(CSR_GEAR_INV, 22'(g));
   endtask

   // wait until every beat is sent and answered, then let the block settle
   task automatic drain();
      while (pending_beats.size() != 0 || expected_tracks.size() != 0 || req_valid)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   // mostly smooth motion with random offsets and table rewrites, some jumps
   task automatic random_run(int n);
      int step;
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0: push_lut(7'($urandom), 18'($urandom));
            1: push_sample(21'($urandom));
            2: push_sample(angle_now + 21'($urandom_range(1048000, 1049100)));
            default: begin
               step = $urandom_range(0, 3) == 0 ? $urandom_range(0, 600000) - 300000 :
                      $urandom_range(0, 4000) - 2000;
               angle_now = angle_now + 21'(step);
               push_sample(angle_now);
            end
         endcase
      end
   endtask

   initial begin
      for (int i = 0; i < 128; i++) offs_tbl[i] = 0;
      for (int i = 0; i < 10; i++) vel_hist[i] = 0;
      last_corr = HALF; turns = '0; first_pending = 1'b1;
      last_pos = 0; avg_vel = 0; last_fvel = 0;
      zero_cfg = 0; eoff_cfg = 0; pp_cfg = 1; rate_cfg = 40000;
      alpha_cfg = 65535; beta_cfg = 0; gear_cfg = 65535;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // zero above half a turn so the first sample counts a turn up
      set_all(21'd1500000, 22'sd1000, 7'd7, 16'd40000, 16'd40000, 16'd20000, 16'd30000);
      // fill the whole offset table, extremes in the mix
      for (int i = 0; i < 128; i++)
         push_lut(7'(i), i == 5 ? -18'sd131072 : i == 6 ? 18'sd131071 :
                  i == 127 ? 18'sd131071 : i == 0 ? -18'sd131072 : 18'($urandom_range(0, 4000) - 2000));
      // directed samples: extremes, last sector wrap, exact half-turn steps
      push_sample(21'd0);
      push_sample(21'h1FFFFF);
      push_sample(21'd0);
      push_sample(21'h1FFFFF);
      push_sample(21'd100000);
      push_sample(21'd100000 + 21'd1048576);
      push_sample(21'd100000);
      push_sample(21'd100000 + 21'd1048577);
      push_sample(21'd2080000);
      push_sample(21'd2097000);
      push_sample(21'h155555);
      push_sample(21'h0AAAAA);
      push_lut(7'd3, 18'sd131071);
      push_lut(7'd3, -18'sd131072);
      push_sample(21'd3 << 14);
      push_sample((21'd3 << 14) + 21'h3FFF);
      push_sample(21'd81920);
      push_sample(21'd81920);
      drain();
      // highest zero, rate, filter and gear settings, 64 pole pairs, most negative offset
      set_all(21'h1FFFFF, 22'h200000, 7'd64, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_run(90);
      drain();
      // low settings, largest offset, with a long receiver hold-off while the sender keeps going
      set_all(21'd0, 22'h1FFFFF, 7'd1, 16'd1, 16'd0, 16'd0, 16'd0);
      hold_req = 1'b1;
      random_run(90);
      drain();
      // zero pole pairs
      set_all(21'd1048576, 22'd0, 7'd0, 16'd40000, 16'd65535, 16'd0, 16'd65535);
      random_run(90);
      drain();
      for (int ph = 0; ph < 2; ph++) begin
         set_all(21'($urandom), 22'($urandom), 7'($urandom_range(1, 64)),
                 16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
                 16'($urandom));
         random_run(90);
         drain();
      end
      // last part without idling
      quiet = 1'b1;
      set_all(21'($urandom), 22'($urandom), 7'($urandom_range(1, 64)),
              16'd40000, 16'd50000, 16'd15000, 16'($urandom));
      random_run(60);
      drain();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
